>>> design/sweep_prune_axis_pass_defines.svh
// assertion macros for the sweep-and-prune axis pass checker
// no dependencies; included by the checker file
`ifndef SWEEP_PRUNE_AXIS_PASS_DEFINES_SVH
`define SWEEP_PRUNE_AXIS_PASS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SAP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sap check failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define SAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sap check failed: next-cycle implication");

`endif

>>> design/sap_pkg.sv
// shared types, constants and layer-pair lookup for the sweep-and-prune pass
// no dependencies
`default_nettype none

package sap_pkg;

  localparam int unsigned MaxActiveDef = 16;
  localparam int unsigned IdW          = 16;
  localparam int unsigned LeadW        = 32;
  localparam int unsigned ExtW         = 31;
  localparam int unsigned TrailW       = 33;
  localparam int unsigned LayerW       = 2;
  localparam int unsigned MaskW        = 6;
  localparam int unsigned Layers       = 3;
  localparam logic [MaskW-1:0] MaskRst = 6'h3f;

  typedef struct packed {
    logic [IdW-1:0]           id;
    logic signed [TrailW-1:0] trail;
    logic [LayerW-1:0]        layer;
  } sap_entry_t;

  typedef struct packed {
    logic keep;
    logic allowed;
  } sap_eval_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PAIR_RD,
    S_PAIR_EV,
    S_OVF,
    S_APPEND
  } sap_state_e;

  function automatic logic pair_allowed(input logic [LayerW-1:0] la,
                                        input logic [LayerW-1:0] lb,
                                        input logic [MaskW-1:0]  mask);
    int unsigned a;
    int unsigned b;
    int unsigned t;
    int unsigned idx;
    logic [MaskW-1:0] sh;
    a = int'(la);
    b = int'(lb);
    if (a >= Layers || b >= Layers) begin
      return 1'b0;
    end
    if (b < a) begin
      t = a;
      a = b;
      b = t;
    end
    idx = a * Layers - ((a * (a - ((a > 0) ? 1 : 0))) >> 1) + (b - a);
    if (idx >= MaskW) begin
      return 1'b0;
    end
    sh = mask >> idx;
    return sh[0];
  endfunction

endpackage

`default_nettype wire

>>> design/sap_eval.sv
// shared compare unit: prune test on the trailing edge and layer-pair check
// depends on sap_pkg
`default_nettype none

module sap_eval (
  input  logic signed [sap_pkg::LeadW-1:0]  lead_i,
  input  logic        [sap_pkg::LayerW-1:0] layer_i,
  input  logic        [sap_pkg::MaskW-1:0]  mask_i,
  input  sap_pkg::sap_entry_t               entry_i,
  output sap_pkg::sap_eval_t                res_o
);

  logic signed [sap_pkg::TrailW-1:0] lead_ext;

  assign lead_ext      = $signed({lead_i[sap_pkg::LeadW-1], lead_i});
  assign res_o.keep    = (entry_i.trail >= lead_ext);
  assign res_o.allowed = sap_pkg::pair_allowed(layer_i, entry_i.layer, mask_i);

endmodule

`default_nettype wire

>>> design/sweep_prune_axis_pass.sv
// sweep-and-prune pass along one axis: active list memory, sequencer, result register
// depends on sap_pkg and sap_eval
//
//   channel   signals                          direction  notes
//   in        in_valid_i / in_ready_o          input      one object per beat
//   out       out_valid_o / out_ready_i        output     one pair or overflow beat
//   cfg       cfg_we_i / cfg_wdata_i           input      layer pair mask, no wait
//
// an object is accepted, then a prune pass reads the n stored entries and compacts
// the survivors, a pair pass walks the entries up to the last permitted pair, and a
// last step appends the object or reports overflow, skipped when overflow rides on
// the pair beats; one compare unit and one list read port serve both passes
// a stalled result beat holds back the next beat; in_ready_o is high only when idle
// reset empties the list and sets the mask to all ones
`default_nettype none

module sweep_prune_axis_pass #(
  parameter int unsigned MAX_ACTIVE = sap_pkg::MaxActiveDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              first_of_sweep_i,
  input  logic                              axis_i,
  input  logic        [sap_pkg::IdW-1:0]    obj_id_i,
  input  logic signed [sap_pkg::LeadW-1:0]  lead_edge_i,
  input  logic        [sap_pkg::ExtW-1:0]   extent_i,
  input  logic        [sap_pkg::LayerW-1:0] layer_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              pair_valid_o,
  output logic        [sap_pkg::IdW-1:0]    earlier_id_o,
  output logic        [sap_pkg::IdW-1:0]    later_id_o,
  output logic                              pair_axis_o,
  output logic                              last_of_item_o,
  output logic                              list_overflow_o,
  input  logic                              cfg_we_i,
  input  logic        [sap_pkg::MaskW-1:0]  cfg_wdata_i
);

  localparam int unsigned IW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int unsigned CW = $clog2(MAX_ACTIVE + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ACTIVE);
  localparam logic [CW-1:0] One    = CW'(1);

  sap_pkg::sap_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] npair_q, npair_d;
  logic [CW-1:0] emit_q, emit_d;
  logic          pend_q, pend_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  logic [sap_pkg::MaskW-1:0] mask_q;

  // latched object
  logic                              axis_q;
  logic        [sap_pkg::IdW-1:0]    id_q;
  logic signed [sap_pkg::LeadW-1:0]  lead_q;
  logic        [sap_pkg::ExtW-1:0]   ext_q;
  logic        [sap_pkg::LayerW-1:0] layer_q;
  logic                              item_ld;

  // result register
  logic                     pv_q, pv_d;
  logic [sap_pkg::IdW-1:0]  eid_q, eid_d;
  logic [sap_pkg::IdW-1:0]  lid_q;
  logic                     pax_q;
  logic                     last_q, last_d;
  logic                     oovf_q, oovf_d;
  logic                     out_ld;

  // active list memory
  sap_pkg::sap_entry_t mem_q [MAX_ACTIVE];
  sap_pkg::sap_entry_t rdata_q;
  sap_pkg::sap_entry_t mem_wdata;
  sap_pkg::sap_entry_t new_entry;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;

  sap_pkg::sap_eval_t ev;
  logic               accept;
  logic               out_free;
  logic               scan_done;
  logic               is_last;

  sap_eval u_eval (
    .lead_i  (lead_q),
    .layer_i (layer_q),
    .mask_i  (mask_q),
    .entry_i (rdata_q),
    .res_o   (ev)
  );

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_done = (rd_idx_q == count_q) && !pend_q;
  assign is_last   = ((emit_q + One) == npair_q);

  assign new_entry.id    = id_q;
  assign new_entry.trail = $signed({lead_q[sap_pkg::LeadW-1], lead_q})
                         + $signed({2'b00, ext_q});
  assign new_entry.layer = layer_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sap_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sap_pkg::S_SCAN;
        end
      end
      sap_pkg::S_SCAN: begin
        if (scan_done) begin
          if (npair_q != '0) begin
            state_d = sap_pkg::S_PAIR_RD;
          end else if (kept_q == MaxCnt) begin
            state_d = sap_pkg::S_OVF;
          end else begin
            state_d = sap_pkg::S_APPEND;
          end
        end
      end
      sap_pkg::S_PAIR_RD: begin
        state_d = sap_pkg::S_PAIR_EV;
      end
      sap_pkg::S_PAIR_EV: begin
        if (!ev.allowed) begin
          state_d = sap_pkg::S_PAIR_RD;
        end else if (out_free) begin
          if (!is_last) begin
            state_d = sap_pkg::S_PAIR_RD;
          end else if (ovf_q) begin
            state_d = sap_pkg::S_IDLE;
          end else begin
            state_d = sap_pkg::S_APPEND;
          end
        end
      end
      sap_pkg::S_OVF: begin
        if (out_free) begin
          state_d = sap_pkg::S_IDLE;
        end
      end
      sap_pkg::S_APPEND: begin
        state_d = sap_pkg::S_IDLE;
      end
      default: begin
        state_d = sap_pkg::S_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    in_ready_o  = (state_q == sap_pkg::S_IDLE);
    count_d     = count_q;
    kept_d      = kept_q;
    rd_idx_d    = rd_idx_q;
    npair_d     = npair_q;
    emit_d      = emit_q;
    pend_d      = 1'b0;
    ovf_d       = ovf_q;
    item_ld     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = kept_q[IW-1:0];
    mem_raddr   = rd_idx_q[IW-1:0];
    mem_wdata   = rdata_q;
    out_ld      = 1'b0;
    pv_d        = 1'b1;
    eid_d       = rdata_q.id;
    last_d      = is_last;
    oovf_d      = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      sap_pkg::S_IDLE: begin
        if (accept) begin
          item_ld  = 1'b1;
          rd_idx_d = '0;
          kept_d   = '0;
          npair_d  = '0;
          emit_d   = '0;
          if (first_of_sweep_i) begin
            count_d = '0;
          end
        end
      end
      sap_pkg::S_SCAN: begin
        if (rd_idx_q != count_q) begin
          mem_re   = 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + One;
        end
        // compact surviving entries toward the head
        if (pend_q && ev.keep) begin
          mem_we = 1'b1;
          kept_d = kept_q + One;
          if (ev.allowed) begin
            npair_d = npair_q + One;
          end
        end
        if (scan_done) begin
          count_d  = kept_q;
          ovf_d    = (kept_q == MaxCnt);
          rd_idx_d = '0;
        end
      end
      sap_pkg::S_PAIR_RD: begin
        mem_re   = 1'b1;
        rd_idx_d = rd_idx_q + One;
      end
      sap_pkg::S_PAIR_EV: begin
        if (ev.allowed && out_free) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          emit_d      = emit_q + One;
        end
      end
      sap_pkg::S_OVF: begin
        pv_d   = 1'b0;
        eid_d  = '0;
        last_d = 1'b1;
        oovf_d = 1'b1;
        if (out_free) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      sap_pkg::S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = count_q[IW-1:0];
        mem_wdata = new_entry;
        count_d   = count_q + One;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sap_pkg::S_IDLE;
      count_q     <= '0;
      kept_q      <= '0;
      rd_idx_q    <= '0;
      npair_q     <= '0;
      emit_q      <= '0;
      pend_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= sap_pkg::MaskRst;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      kept_q      <= kept_d;
      rd_idx_q    <= rd_idx_d;
      npair_q     <= npair_d;
      emit_q      <= emit_d;
      pend_q      <= pend_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ld) begin
      axis_q  <= axis_i;
      id_q    <= obj_id_i;
      lead_q  <= lead_edge_i;
      ext_q   <= extent_i;
      layer_q <= layer_i;
    end
    if (out_ld) begin
      pv_q   <= pv_d;
      eid_q  <= eid_d;
      lid_q  <= id_q;
      pax_q  <= axis_q;
      last_q <= last_d;
      oovf_q <= oovf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pair_valid_o    = pv_q;
  assign earlier_id_o    = eid_q;
  assign later_id_o      = lid_q;
  assign pair_axis_o     = pax_q;
  assign last_of_item_o  = last_q;
  assign list_overflow_o = oovf_q;

endmodule

`default_nettype wire

>>> design/sap_chk.sv
// port-level checker for the sweep-and-prune pass, bound to the top level
// depends on sap_pkg and sweep_prune_axis_pass_defines.svh
`default_nettype none
`include "sweep_prune_axis_pass_defines.svh"

module sap_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              pair_valid_o,
  input logic        [sap_pkg::IdW-1:0]    earlier_id_o,
  input logic        [sap_pkg::IdW-1:0]    later_id_o,
  input logic                              last_of_item_o,
  input logic                              list_overflow_o
);

  `SAP_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni,
                   in_valid_i && in_ready_o, !in_ready_o)

  `SAP_ASSERT_SAME(a_ovf_only_beat, clk_i, rst_ni,
                   out_valid_o && !pair_valid_o,
                   list_overflow_o && last_of_item_o && (earlier_id_o == '0))

  `SAP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   out_valid_o && !out_ready_i,
                   out_valid_o && $stable(earlier_id_o) && $stable(later_id_o))

  // more beats of the same object follow, so the input side stays busy
  `SAP_ASSERT_SAME(a_busy_while_open, clk_i, rst_ni,
                   out_valid_o && !last_of_item_o, !in_ready_o)

endmodule

bind sweep_prune_axis_pass sap_chk u_sap_chk (.*);

`default_nettype wire

>>> verif/tb_sweep_prune_axis_pass.sv
// self-checking testbench for the sweep-and-prune axis pass: random valid/ready
// traffic on both channels, a layer pair mask swept over several settings
// depends on sap_pkg and sweep_prune_axis_pass
`timescale 1ns / 100ps

module tb_sweep_prune_axis_pass;

  localparam int unsigned MaxActive   = sap_pkg::MaxActiveDef;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 28;
  localparam int unsigned NumPhases   = 8;

  typedef struct packed {
    logic                       first;
    logic                       axis;
    logic [sap_pkg::IdW-1:0]    id;
    logic [sap_pkg::LeadW-1:0]  lead;
    logic [sap_pkg::ExtW-1:0]   ext;
    logic [sap_pkg::LayerW-1:0] layer;
  } sweep_obj_t;

  typedef struct packed {
    logic                    pair_valid;
    logic [sap_pkg::IdW-1:0] earlier_id;
    logic [sap_pkg::IdW-1:0] later_id;
    logic                    axis;
    logic                    last;
    logic                    ovf;
  } pair_beat_t;

  logic                              clk_i            = 1'b0;
  logic                              rst_ni           = 1'b0;
  logic                              in_valid_i       = 1'b0;
  logic                              in_ready_o;
  logic                              first_of_sweep_i = 1'b0;
  logic                              axis_i           = 1'b0;
  logic        [sap_pkg::IdW-1:0]    obj_id_i         = '0;
  logic signed [sap_pkg::LeadW-1:0]  lead_edge_i      = '0;
  logic        [sap_pkg::ExtW-1:0]   extent_i         = '0;
  logic        [sap_pkg::LayerW-1:0] layer_i          = '0;
  logic                              out_valid_o;
  logic                              out_ready_i      = 1'b0;
  logic                              pair_valid_o;
  logic        [sap_pkg::IdW-1:0]    earlier_id_o;
  logic        [sap_pkg::IdW-1:0]    later_id_o;
  logic                              pair_axis_o;
  logic                              last_of_item_o;
  logic                              list_overflow_o;
  logic                              cfg_we_i         = 1'b0;
  logic        [sap_pkg::MaskW-1:0]  cfg_wdata_i      = '0;

  sweep_obj_t  pending_objs[$];
  pair_beat_t  expected_beats[$];

  sap_pkg::sap_entry_t       live_list[MaxActive];
  int                        live_count = 0;
  logic [sap_pkg::MaskW-1:0] mask_model = sap_pkg::MaskRst;

  bit idle_on = 1'b1;
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int out_cnt = 0;
  int out_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int n_pairs = 0;
  int n_ovf_beats = 0;
  int n_masks = 0;
  int cycles = 0;

  sweep_prune_axis_pass dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_of_sweep_i (first_of_sweep_i),
    .axis_i           (axis_i),
    .obj_id_i         (obj_id_i),
    .lead_edge_i      (lead_edge_i),
    .extent_i         (extent_i),
    .layer_i          (layer_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pair_valid_o     (pair_valid_o),
    .earlier_id_o     (earlier_id_o),
    .later_id_o       (later_id_o),
    .pair_axis_o      (pair_axis_o),
    .last_of_item_o   (last_of_item_o),
    .list_overflow_o  (list_overflow_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic layers_may_touch(input logic [sap_pkg::LayerW-1:0] la,
                                            input logic [sap_pkg::LayerW-1:0] lb,
                                            input logic [sap_pkg::MaskW-1:0]  m);
    int lo;
    int hi;
    int bitpos;
    lo = (la < lb) ? int'(la) : int'(lb);
    hi = (la < lb) ? int'(lb) : int'(la);
    if (hi >= int'(sap_pkg::Layers)) return 1'b0;
    bitpos = lo * int'(sap_pkg::Layers) - (lo * (lo - 1)) / 2 + (hi - lo);
    if (bitpos >= int'(sap_pkg::MaskW)) return 1'b0;
    return m[bitpos];
  endfunction

  // prune the live list, store the object or flag overflow, and queue the pair beats
  task automatic predict_pairs(input sweep_obj_t o);
    logic signed [sap_pkg::TrailW-1:0] lead_w;
    logic [sap_pkg::IdW-1:0]           hit_ids[MaxActive];
    sap_pkg::sap_entry_t               ent;
    pair_beat_t                        b;
    int                                kept;
    int                                n;
    logic                              ovf;
    kept = 0;
    n = 0;
    if (o.first) live_count = 0;
    lead_w = {o.lead[sap_pkg::LeadW-1], o.lead};
    for (int i = 0; i < live_count; i++) begin
      ent = live_list[i];
      if (!(lead_w > $signed(ent.trail))) begin
        live_list[kept] = ent;
        kept++;
        if (layers_may_touch(o.layer, ent.layer, mask_model)) begin
          hit_ids[n] = ent.id;
          n++;
        end
      end
    end
    live_count = kept;
    ovf = (live_count >= MaxActive);
    if (!ovf) begin
      ent.id = o.id;
      ent.trail = lead_w + $signed({2'b00, o.ext});
      ent.layer = o.layer;
      live_list[live_count] = ent;
      live_count++;
    end
    if (ovf && n == 0) begin
      b = '{pair_valid: 1'b0, earlier_id: '0, later_id: o.id, axis: o.axis,
            last: 1'b1, ovf: 1'b1};
      expected_beats.insert(expected_beats.size(), b);
    end
    for (int k = 0; k < n; k++) begin
      b = '{pair_valid: 1'b1, earlier_id: hit_ids[k], later_id: o.id, axis: o.axis,
            last: (k == n - 1), ovf: ovf};
      expected_beats.insert(expected_beats.size(), b);
    end
  endtask

  task automatic check_beat(input pair_beat_t got);
    pair_beat_t want;
    if (got.ovf) n_ovf_beats++;
    if (got.pair_valid) n_pairs++;
    if (expected_beats.size() == 0) begin
      errors++;
      if (errors <= MaxReports)
        $display("unexpected result beat: pv=%0d e=%h l=%h ax=%0d last=%0d ovf=%0d",
                 got.pair_valid, got.earlier_id, got.later_id, got.axis, got.last,
                 got.ovf);
    end else begin
      want = expected_beats.pop_front();
      if (got.pair_valid !== want.pair_valid || got.earlier_id !== want.earlier_id ||
          got.later_id !== want.later_id || got.axis !== want.axis ||
          got.last !== want.last || got.ovf !== want.ovf) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("mismatch exp: pv=%0d e=%h l=%h ax=%0d last=%0d ovf=%0d",
                   want.pair_valid, want.earlier_id, want.later_id, want.axis,
                   want.last, want.ovf);
          $display("         got: pv=%0d e=%h l=%h ax=%0d last=%0d ovf=%0d",
                   got.pair_valid, got.earlier_id, got.later_id, got.axis, got.last,
                   got.ovf);
        end
      end
    end
  endtask

  // monitor: result beats are checked first, then an accepted object is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_cnt++;
        check_beat('{pair_valid: pair_valid_o, earlier_id: earlier_id_o,
                     later_id: later_id_o, axis: pair_axis_o, last: last_of_item_o,
                     ovf: list_overflow_o});
      end
      if (in_valid_i && in_ready_o) begin
        accepted_cnt++;
        predict_pairs('{first: first_of_sweep_i, axis: axis_i, id: obj_id_i,
                        lead: lead_edge_i, ext: extent_i, layer: layer_i});
      end
    end
  end

  // driver: holds a beat until taken, then idles for the drawn gap
  always @(negedge clk_i) begin
    sweep_obj_t o;
    if (rst_ni) begin
      if (!in_valid_i || issued_cnt == accepted_cnt) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_objs.size() > 0) begin
          o = pending_objs.pop_front();
          first_of_sweep_i <= o.first;
          axis_i           <= o.axis;
          obj_id_i         <= o.id;
          lead_edge_i      <= o.lead;
          extent_i         <= o.ext;
          layer_i          <= o.layer;
          in_valid_i       <= 1'b1;
          issued_cnt++;
          gap_left = idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls after each result beat for a drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_seen != out_cnt) begin
        out_seen = out_cnt;
        stall_left = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

  task automatic push_obj(input logic f, input logic ax,
                          input logic [sap_pkg::IdW-1:0] id,
                          input logic [sap_pkg::LeadW-1:0] lead,
                          input logic [sap_pkg::ExtW-1:0] ext,
                          input logic [sap_pkg::LayerW-1:0] lay);
    sweep_obj_t o;
    o = '{first: f, axis: ax, id: id, lead: lead, ext: ext, layer: lay};
    pending_objs.insert(pending_objs.size(), o);
  endtask

  task automatic set_mask(input logic [sap_pkg::MaskW-1:0] m);
    @(negedge clk_i);
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mask_model = m;
    n_masks++;
  endtask

  task automatic wait_drained;
    while (!(pending_objs.size() == 0 && issued_cnt == accepted_cnt &&
             expected_beats.size() == 0))
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sorted sweep with random content; dense sweeps pile up and can overflow the list
  task automatic gen_sweep(input int len, input bit dense, inout int count);
    longint                     pos;
    logic                       ax;
    logic [sap_pkg::ExtW-1:0]   ext;
    logic [sap_pkg::LayerW-1:0] lay;
    ax = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       pos = -64'sd2147483648 + longint'($urandom_range(0, 5000));
      1:       pos = longint'(int'($urandom));
      2:       pos = 2147483647 - longint'($urandom_range(0, 20000));
      default: pos = longint'($urandom_range(0, 10000)) - 5000;
    endcase
    for (int i = 0; i < len; i++) begin
      if (dense) ext = 31'($urandom_range(20000, 200000));
      else if ($urandom_range(0, 15) == 0) ext = {1'b1, 30'($urandom)};
      else ext = 31'($urandom_range(0, 12000));
      lay = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      push_obj(i == 0, ax, 16'($urandom), pos[31:0], ext, lay);
      count++;
      pos += dense ? longint'($urandom_range(0, 3)) : longint'($urandom_range(0, 4000));
      if (pos > 2147483647) pos = 2147483647;
    end
  endtask

  initial begin
    int count;
    int r;
    logic [sap_pkg::MaskW-1:0] m;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_mask(6'h3f);
    // extreme edges: most negative lead with widest extent, then a drop
    push_obj(1'b1, 1'b0, 16'h0000, 32'h8000_0000, 31'h7fff_ffff, 2'd0);
    push_obj(1'b0, 1'b1, 16'hffff, 32'h7fff_ffff, 31'h0000_0000, 2'd2);
    // trailing edge equal to the new lead still overlaps
    push_obj(1'b0, 1'b1, 16'h0001, 32'h7fff_ffff, 31'h7fff_ffff, 2'd1);
    // layer out of range never pairs
    push_obj(1'b0, 1'b0, 16'h0002, 32'h7fff_ffff, 31'h0000_0010, 2'd3);
    // fill the list, then overflow with pairs and without
    for (int i = 0; i < 17; i++)
      push_obj(i == 0, 1'b0, 16'h0100 + 16'(i), 32'h0000_0064, 31'h1000_0000,
               2'(i % 3));
    push_obj(1'b0, 1'b1, 16'h0200, 32'h0000_0064, 31'h0000_0001, 2'd3);
    // lead beyond every trailing edge drops the whole list
    push_obj(1'b0, 1'b0, 16'h0300, 32'h7fff_ff00, 31'h0000_0001, 2'd1);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       m = 6'h00;
        1:       m = 6'h3f;
        2:       m = 6'b1 << $urandom_range(0, 5);
        5:       m = 6'h3f ^ (6'b1 << $urandom_range(0, 5));
        7:       m = 6'h3f;
        default: m = 6'($urandom_range(0, 63));
      endcase
      set_mask(m);
      idle_on = (p % 3 != 2);
      count = 0;
      while (count < PhaseItems) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          for (int j = $urandom_range(1, 3); j > 0; j--) begin
            push_obj(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom),
                     $urandom, 31'($urandom), 2'($urandom_range(0, 3)));
            count++;
          end
        end else if (r < 4) begin
          gen_sweep($urandom_range(14, 22), 1'b1, count);
        end else begin
          gen_sweep($urandom_range(1, 12), 1'b0, count);
        end
      end
      wait_drained();
    end

    if (expected_beats.size() != 0) begin
      errors++;
      $display("%0d expected result beats never arrived", expected_beats.size());
    end
    $display("run covered %0d objects over %0d mask settings", accepted_cnt, n_masks);
    $display("%0d pair beats and %0d overflow beats seen, %0d mismatches",
             n_pairs, n_ovf_beats, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
